[hdl/crf_pkg.sv]
// shared types, constants and helpers of the clipped rectangle fill engine
package crf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int PIXEL_BITS = 32;
  localparam int FRAME_AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);

  localparam logic [2:0] ACT_FILL   = 3'd0;
  localparam logic [2:0] ACT_PUSH   = 3'd1;
  localparam logic [2:0] ACT_POP    = 3'd2;
  localparam logic [2:0] ACT_RECALC = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic cfg_frame_width  = 1'b0;
  localparam logic cfg_frame_height = 1'b1;

  typedef enum logic [2:0] {
    K_FILL, K_PUSH, K_POP, K_RECALC, K_READ, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            rect_x;
    logic [7:0]            rect_y;
    logic [7:0]            rect_width;
    logic [7:0]            rect_height;
    logic [PIXEL_BITS-1:0] fill_color;
    logic                  recompute;
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SETUP, S_FILL, S_RECALC, S_RDWAIT, S_EMIT
  } state_t;

  function automatic logic [6:0] narrow(input logic [6:0] s, input logic [7:0] off,
                                        input logic [7:0] bs, input logic [7:0] cap);
    logic [7:0] d;
    logic [7:0] n;
    d = {1'b0, s} - off;
    if ({1'b0, s} >= off) n = (d < bs) ? d : bs;
    else n = bs;
    if (n > cap) n = cap;
    return n[6:0];
  endfunction

endpackage

[hdl/clipped_rect_fill_with_clip_stack_top.sv]
// top level of the clipped rectangle fill engine
// Commands enter through a two-entry queue and are carried out one at a time.
// A fill writes one pixel per cycle through the single frame memory port.
// When a push or pop that succeeds asks for it, the clip is recomputed by
// walking the boundary stack one entry per cycle.
// After reset all 4096 pixels of the frame memory are cleared to zero, one
// pixel after another, during which no command is accepted (configuration
// writes still are).
module clipped_rect_fill_with_clip_stack_top #(
  parameter int STACK_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rect_x, rect_y, rect_width, rect_height, fill_color, recompute
  input  logic [71:0]  s_tdata,
  // action
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, area_x0, area_y0, area_x1, area_y1, pixel_value,
  // clip_x, clip_y, clip_width, clip_height
  output logic [103:0] m_tdata
);

  logic          q_full, q_push, q_pop, q_valid, clearing;
  crf_pkg::cmd_t q_item, q_head;

  crf_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .enable   (!clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  crf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  crf_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[hdl/crf_front.sv]
// input side: accepts transfers and classifies each action
module crf_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [71:0]         s_tdata,
  input  logic [2:0]          s_tuser,
  input  logic                enable,
  input  logic                q_full,
  output logic                q_push,
  output crf_pkg::cmd_t       q_item
);

  assign s_tready = enable && !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_item.rect_x      = s_tdata[7:0];
    q_item.rect_y      = s_tdata[15:8];
    q_item.rect_width  = s_tdata[23:16];
    q_item.rect_height = s_tdata[31:24];
    q_item.fill_color  = s_tdata[63:32];
    q_item.recompute   = s_tdata[64];
    unique case (s_tuser)
      crf_pkg::ACT_FILL:   q_item.kind = crf_pkg::K_FILL;
      crf_pkg::ACT_PUSH:   q_item.kind = crf_pkg::K_PUSH;
      crf_pkg::ACT_POP:    q_item.kind = crf_pkg::K_POP;
      crf_pkg::ACT_RECALC: q_item.kind = crf_pkg::K_RECALC;
      crf_pkg::ACT_READ:   q_item.kind = crf_pkg::K_READ;
      default:             q_item.kind = crf_pkg::K_NOP;
    endcase
  end

endmodule

[hdl/crf_queue.sv]
// two-entry command queue between front and back
module crf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  crf_pkg::cmd_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output crf_pkg::cmd_t head
);

  crf_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/crf_back.sv]
// execution side: frame memory, boundary stack, clip state and result register
module crf_back #(
  parameter int STACK_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic          q_valid,
  input  crf_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          clearing,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam int AW = crf_pkg::FRAME_AW;
  localparam int PB = crf_pkg::PIXEL_BITS;
  localparam int XW = crf_pkg::XW;
  localparam int YW = crf_pkg::YW;
  localparam logic [6:0] CAP_W = 7'(crf_pkg::MAX_WIDTH);
  localparam logic [6:0] CAP_H = 7'(crf_pkg::MAX_HEIGHT);

  crf_pkg::state_t state, state_next;

  logic [PB-1:0] frame_mem [2**AW];
  logic [PB-1:0] mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [PB-1:0] mem_wdata;

  logic [31:0]   stack [STACK_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] walk;

  logic [6:0]  frame_width, frame_height, fw, fh;
  logic [10:0] clip_x, clip_y;
  logic [6:0]  clip_width, clip_height;
  logic [AW-1:0] clr_addr;

  crf_pkg::cmd_t cmd;
  logic [1:0]    r_status;
  logic [7:0]    r_x0, r_y0, r_x1, r_y1;
  logic [PB-1:0] r_pix;

  logic [XW-1:0] x, sx, ex_m1;
  logic [YW-1:0] y, sy, ey_m1;
  logic [AW-1:0] row_base;

  // fill geometry
  logic [7:0]  w, h;
  logic [11:0] fsx, fsy, lim_x, lim_y;
  logic [12:0] end_x, end_y;
  logic [6:0]  mx, my, fex, fey;
  logic        f_none, f_empty;
  logic        rd_in;
  logic [AW-1:0] rd_addr;
  logic [31:0] walk_e, pop_e;
  logic [CW-1:0] count_m1;

  assign fw = (frame_width  > CAP_W) ? CAP_W : frame_width;
  assign fh = (frame_height > CAP_H) ? CAP_H : frame_height;
  assign clearing = (state == crf_pkg::S_CLEAR);

  always_comb begin
    w     = (cmd.rect_width  != 8'd0) ? cmd.rect_width  : {1'b0, clip_width};
    h     = (cmd.rect_height != 8'd0) ? cmd.rect_height : {1'b0, clip_height};
    fsx   = {1'b0, clip_x} + {4'b0, cmd.rect_x};
    fsy   = {1'b0, clip_y} + {4'b0, cmd.rect_y};
    lim_x = {1'b0, clip_x} + {5'b0, clip_width};
    lim_y = {1'b0, clip_y} + {5'b0, clip_height};
    mx    = (lim_x < {5'b0, fw}) ? lim_x[6:0] : fw;
    my    = (lim_y < {5'b0, fh}) ? lim_y[6:0] : fh;
    end_x = {1'b0, fsx} + {5'b0, w};
    end_y = {1'b0, fsy} + {5'b0, h};
    fex   = (end_x < {6'b0, mx}) ? end_x[6:0] : mx;
    fey   = (end_y < {6'b0, my}) ? end_y[6:0] : my;
    f_none  = ({5'b0, fex} < fsx) || ({5'b0, fey} < fsy);
    f_empty = ({5'b0, fex} == fsx) || ({5'b0, fey} == fsy);
    rd_in   = (cmd.rect_x < {1'b0, fw}) && (cmd.rect_y < {1'b0, fh});
    rd_addr = AW'(cmd.rect_y[YW-1:0]) * AW'(fw) + AW'(cmd.rect_x[XW-1:0]);
    count_m1 = count - 1'b1;
    walk_e  = stack[walk[IW-1:0]];
    pop_e   = stack[count_m1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= crf_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = row_base + AW'(x);
    mem_wdata  = cmd.fill_color;
    unique case (state)
      crf_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
        if (&clr_addr) state_next = crf_pkg::S_IDLE;
      end
      crf_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = crf_pkg::S_EXEC;
        end
      end
      crf_pkg::S_EXEC: begin
        unique case (cmd.kind)
          crf_pkg::K_FILL:
            state_next = (f_none || f_empty) ? crf_pkg::S_EMIT : crf_pkg::S_SETUP;
          crf_pkg::K_PUSH:
            state_next = (count >= DEPTH_C || !cmd.recompute) ?
                         crf_pkg::S_EMIT : crf_pkg::S_RECALC;
          crf_pkg::K_POP:
            state_next = (count == '0 || !cmd.recompute) ?
                         crf_pkg::S_EMIT : crf_pkg::S_RECALC;
          crf_pkg::K_RECALC: state_next = crf_pkg::S_RECALC;
          crf_pkg::K_READ: begin
            mem_addr   = rd_addr;
            state_next = rd_in ? crf_pkg::S_RDWAIT : crf_pkg::S_EMIT;
          end
          default: state_next = crf_pkg::S_EMIT;
        endcase
      end
      crf_pkg::S_SETUP: state_next = crf_pkg::S_FILL;
      crf_pkg::S_FILL: begin
        mem_we = 1'b1;
        if (x == ex_m1 && y == ey_m1) state_next = crf_pkg::S_EMIT;
      end
      crf_pkg::S_RECALC: begin
        if (walk == count) state_next = crf_pkg::S_EMIT;
      end
      crf_pkg::S_RDWAIT: state_next = crf_pkg::S_EMIT;
      crf_pkg::S_EMIT: begin
        if (!m_tvalid || m_tready) state_next = crf_pkg::S_IDLE;
      end
      default: state_next = crf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_addr] <= mem_wdata;
    mem_q <= frame_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      count        <= '0;
      walk         <= '0;
      clip_x       <= '0;
      clip_y       <= '0;
      clip_width   <= CAP_W;
      clip_height  <= CAP_H;
      frame_width  <= 7'd64;
      frame_height <= 7'd64;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == crf_pkg::cfg_frame_width) frame_width <= cfg_data;
        else frame_height <= cfg_data;
      end
      if (m_tvalid && m_tready && state != crf_pkg::S_EMIT) m_tvalid <= 1'b0;
      unique case (state)
        crf_pkg::S_CLEAR: clr_addr <= clr_addr + 1'b1;
        crf_pkg::S_IDLE: begin
          if (q_valid) cmd <= q_head;
          r_status <= crf_pkg::ST_OK;
          r_x0 <= '0; r_y0 <= '0; r_x1 <= '0; r_y1 <= '0;
          r_pix <= '0;
        end
        crf_pkg::S_EXEC: begin
          walk        <= '0;
          unique case (cmd.kind)
            crf_pkg::K_FILL: begin
              if (f_none) r_status <= crf_pkg::ST_NONE;
              else begin
                r_x0 <= fsx[7:0]; r_y0 <= fsy[7:0];
                r_x1 <= {1'b0, fex}; r_y1 <= {1'b0, fey};
              end
              sx    <= fsx[XW-1:0];
              sy    <= fsy[YW-1:0];
              ex_m1 <= XW'(fex - 7'd1);
              ey_m1 <= YW'(fey - 7'd1);
            end
            crf_pkg::K_PUSH: begin
              if (count >= DEPTH_C) r_status <= crf_pkg::ST_FULL;
              else begin
                stack[count[IW-1:0]] <= {cmd.rect_height, cmd.rect_width,
                                         cmd.rect_y, cmd.rect_x};
                count <= count + 1'b1;
              end
            end
            crf_pkg::K_POP: begin
              if (count == '0) r_status <= crf_pkg::ST_EMPTY;
              else begin
                count <= count_m1;
                r_x0 <= pop_e[7:0];   r_y0 <= pop_e[15:8];
                r_x1 <= pop_e[23:16]; r_y1 <= pop_e[31:24];
              end
            end
            crf_pkg::K_READ: if (!rd_in) r_status <= crf_pkg::ST_NONE;
            default: ;
          endcase
          if (state_next == crf_pkg::S_RECALC) begin
            clip_x      <= '0;
            clip_y      <= '0;
            clip_width  <= fw;
            clip_height <= fh;
          end
        end
        crf_pkg::S_SETUP: begin
          row_base <= AW'(sy) * AW'(fw);
          x        <= sx;
          y        <= sy;
        end
        crf_pkg::S_FILL: begin
          if (x == ex_m1) begin
            x        <= sx;
            y        <= y + 1'b1;
            row_base <= row_base + AW'(fw);
          end else x <= x + 1'b1;
        end
        crf_pkg::S_RECALC: begin
          if (walk != count) begin
            clip_width  <= crf_pkg::narrow(clip_width, walk_e[7:0], walk_e[23:16],
                                           {1'b0, CAP_W});
            clip_height <= crf_pkg::narrow(clip_height, walk_e[15:8], walk_e[31:24],
                                           {1'b0, CAP_H});
            clip_x <= clip_x + {3'b0, walk_e[7:0]};
            clip_y <= clip_y + {3'b0, walk_e[15:8]};
            walk   <= walk + 1'b1;
          end
        end
        crf_pkg::S_RDWAIT: r_pix <= mem_q;
        crf_pkg::S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b0, clip_height, clip_width, clip_y, clip_x, r_pix,
                         r_y1, r_x1, r_y0, r_x0, r_status};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/crf_checker.sv]
// port-level checks of the fill engine, bound to the top level
module crf_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_we,
  input logic         cfg_index,
  input logic [6:0]   cfg_data,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [71:0]  s_tdata,
  input logic [2:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("activity right after reset");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[94:88] <= 7'd64 && m_tdata[101:95] <= 7'd64)
    else $error("clip size above cap");

  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[65:34] == '0)
    else $error("pixel with error status");

endmodule

bind clipped_rect_fill_with_clip_stack_top crf_checker u_crf_checker (.*);
